### rtl/kdhr_pkg.sv
// ----------------------------------------------------------------------------
// kdhr_pkg
// shared types and constants for the key debounce, hold and repeat unit
// ----------------------------------------------------------------------------
package kdhr_pkg;

    localparam int NUM_KEYS_DEF = 5;
    localparam int KEY_W        = 3;
    localparam int KIND_W       = 2;
    localparam int DLY_W        = 16;
    localparam int FLAGS_W      = 5;
    localparam int CFG_IDX_W    = 2;

    // mode flag bit positions
    localparam int FLAG_ENSURE = 0;
    localparam int FLAG_PRESS  = 1;
    localparam int FLAG_HOLD   = 2;
    localparam int FLAG_REPEAT = 3;
    localparam int FLAG_BLOCK  = 4;

    // event kinds
    localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
    localparam logic [KIND_W-1:0] EV_RELEASE = 2'd1;
    localparam logic [KIND_W-1:0] EV_HOLD    = 2'd2;
    localparam logic [KIND_W-1:0] EV_REPEAT  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCAN_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENSURE_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_DELAY   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY = 2'd3;

    // configuration reset values
    localparam logic [DLY_W-1:0] SCAN_STEP_RST    = 16'd10;
    localparam logic [DLY_W-1:0] ENSURE_DELAY_RST = 16'd20;
    localparam logic [DLY_W-1:0] HOLD_DELAY_RST   = 16'd1000;
    localparam logic [DLY_W-1:0] REPEAT_DELAY_RST = 16'd200;

    localparam logic [KEY_W-1:0] KEY_NONE = '0;

    typedef struct packed {
        logic [DLY_W-1:0] scan_step;
        logic [DLY_W-1:0] ensure_delay;
        logic [DLY_W-1:0] hold_delay;
        logic [DLY_W-1:0] repeat_delay;
    } kdhr_cfg_t;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] kind;
        logic [KEY_W-1:0]  key;
    } kdhr_event_t;

endpackage

### rtl/key_debounce_hold_repeat_unit.sv
// path: an accepted input word is held in the input register stage, and its result word is
//   registered in the result register stage once that stage is free or being drained
// throughput: one word per clock while not stalled by out_ready, one state update per tick
// reset: rst_n clears all key state and restores the register defaults
//   (scan step 10, ensure 20, hold 1000, repeat 200)
// ----------------------------------------------------------------------------
// key_debounce_hold_repeat_unit
// debounced single-key scanner with press, hold, repeat and release events
// ----------------------------------------------------------------------------
module key_debounce_hold_repeat_unit #(
    parameter int NUM_KEYS = kdhr_pkg::NUM_KEYS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // scan tick channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [NUM_KEYS-1:0]             pins_n,
    input  logic                            block_request,
    // event channel, one word per tick
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            event_valid,
    output logic [kdhr_pkg::KIND_W-1:0]     event_kind,
    output logic [kdhr_pkg::KEY_W-1:0]      event_key,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kdhr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kdhr_pkg::DLY_W-1:0]      cfg_data
);
    import kdhr_pkg::*;

    // input register stage
    logic                in_valid_reg;
    logic [NUM_KEYS-1:0] pins_reg;
    logic                block_reg;

    // result register stage
    logic                out_valid_reg;
    kdhr_event_t         ev_reg;

    logic                advance;
    logic [KEY_W-1:0]    key;
    kdhr_event_t         ev;
    kdhr_cfg_t           cfg;

    // the held tick moves on whenever the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    kdhr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    kdhr_encoder #(
        .NUM_KEYS (NUM_KEYS)
    ) u_enc (
        .pins_n (pins_reg),
        .key    (key)
    );

    kdhr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (advance),
        .key       (key),
        .block_req (block_reg),
        .cfg       (cfg),
        .ev        (ev)
    );

    // capture a new tick whenever the stage is empty or emptying
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            pins_reg  <= pins_n;
            block_reg <= block_request;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ev_reg <= ev;
        end
    end

    assign out_valid   = out_valid_reg;
    assign event_valid = ev_reg.valid;
    assign event_kind  = ev_reg.kind;
    assign event_key   = ev_reg.key;

`ifndef SYNTH
    // a suppressed or empty tick reports all-zero fields
    a_quiet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !event_valid) |-> (event_kind == EV_PRESS && event_key == KEY_NONE))
        else $error("non-event word carries data");

    a_event_has_key: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && event_valid) |-> (event_key != KEY_NONE))
        else $error("event without a key");

    // a stalled result must not be overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !advance)
        else $error("result register overwritten while stalled");
`endif

endmodule

### rtl/kdhr_encoder.sv
// ----------------------------------------------------------------------------
// kdhr_encoder
// priority encoder from active-low key pins to a key code, lowest pin wins
// ----------------------------------------------------------------------------
module kdhr_encoder #(
    parameter int NUM_KEYS = kdhr_pkg::NUM_KEYS_DEF
) (
    input  logic [NUM_KEYS-1:0]         pins_n,
    output logic [kdhr_pkg::KEY_W-1:0]  key
);
    import kdhr_pkg::*;

    logic found;

    always_comb
    begin
        found = 1'b0;
        key   = KEY_NONE;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (!found && !pins_n[i])
            begin
                found = 1'b1;
                key   = KEY_W'(i + 1);
            end
        end
    end

endmodule

### rtl/kdhr_cfg_regs.sv
// ----------------------------------------------------------------------------
// kdhr_cfg_regs
// configuration register file, written one word per handshake
// ----------------------------------------------------------------------------
module kdhr_cfg_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [kdhr_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [kdhr_pkg::DLY_W-1:0]      wr_data,
    output kdhr_pkg::kdhr_cfg_t             cfg
);
    import kdhr_pkg::*;

    kdhr_cfg_t cfg_reg;
    kdhr_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_SCAN_STEP:    cfg_next.scan_step    = wr_data;
                REG_ENSURE_DELAY: cfg_next.ensure_delay = wr_data;
                REG_HOLD_DELAY:   cfg_next.hold_delay   = wr_data;
                REG_REPEAT_DELAY: cfg_next.repeat_delay = wr_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.scan_step    <= SCAN_STEP_RST;
            cfg_reg.ensure_delay <= ENSURE_DELAY_RST;
            cfg_reg.hold_delay   <= HOLD_DELAY_RST;
            cfg_reg.repeat_delay <= REPEAT_DELAY_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/kdhr_core.sv
// ----------------------------------------------------------------------------
// kdhr_core
// debounce, hold and repeat state with per-tick event decision
// ----------------------------------------------------------------------------
module kdhr_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        tick,
    input  logic [kdhr_pkg::KEY_W-1:0]  key,
    input  logic                        block_req,
    input  kdhr_pkg::kdhr_cfg_t         cfg,
    output kdhr_pkg::kdhr_event_t       ev
);
    import kdhr_pkg::*;

    logic [FLAGS_W-1:0] flags_reg, flags_next, flags_cur;
    logic [KEY_W-1:0]   held_reg, held_next;
    logic [KEY_W-1:0]   cand_reg, cand_next;
    logic [DLY_W-1:0]   count_reg, count_next;
    logic               step_ok;
    logic [DLY_W-1:0]   count_dec;
    logic               emit_ok;

    assign step_ok   = (count_reg >= cfg.scan_step);
    assign count_dec = count_reg - cfg.scan_step;

    always_comb
    begin
        // block request only latches while something is in progress
        flags_cur = flags_reg;
        if (block_req && (flags_reg != '0))
        begin
            flags_cur[FLAG_BLOCK] = 1'b1;
        end
        emit_ok    = !flags_cur[FLAG_BLOCK];
        flags_next = flags_cur;
        held_next  = held_reg;
        cand_next  = cand_reg;
        count_next = count_reg;
        ev         = '0;

        if (flags_cur[FLAG_ENSURE])
        begin
            if (step_ok)
            begin
                count_next = count_dec;
            end
            else
            begin
                flags_next[FLAG_ENSURE] = 1'b0;
                if (key == cand_reg)
                begin
                    held_next              = cand_reg;
                    flags_next[FLAG_PRESS] = 1'b1;
                    count_next             = cfg.hold_delay;
                    if (emit_ok)
                    begin
                        ev = '{valid: 1'b1, kind: EV_PRESS, key: cand_reg};
                    end
                end
            end
        end
        else if (flags_cur[FLAG_PRESS])
        begin
            if (key == KEY_NONE)
            begin
                if (emit_ok)
                begin
                    ev = '{valid: 1'b1, kind: EV_RELEASE, key: held_reg};
                end
                held_next  = KEY_NONE;
                flags_next = '0;
                count_next = '0;
            end
            else if (step_ok)
            begin
                count_next = count_dec;
            end
            else if (!flags_cur[FLAG_HOLD])
            begin
                flags_next[FLAG_HOLD] = 1'b1;
                count_next            = cfg.repeat_delay;
                if (emit_ok)
                begin
                    ev = '{valid: 1'b1, kind: EV_HOLD, key: held_reg};
                end
            end
            else
            begin
                flags_next[FLAG_REPEAT] = 1'b1;
                count_next              = cfg.repeat_delay;
                if (emit_ok)
                begin
                    ev = '{valid: 1'b1, kind: EV_REPEAT, key: held_reg};
                end
            end
        end
        else if (key != KEY_NONE)
        begin
            cand_next               = key;
            flags_next[FLAG_ENSURE] = 1'b1;
            count_next              = cfg.ensure_delay;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            held_reg  <= KEY_NONE;
            cand_reg  <= KEY_NONE;
            count_reg <= '0;
        end
        else if (tick)
        begin
            flags_reg <= flags_next;
            held_reg  <= held_next;
            cand_reg  <= cand_next;
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    // a confirmed key exists exactly while pressed
    a_held_press: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg[FLAG_PRESS] == (held_reg != KEY_NONE))
        else $error("held key and press flag disagree");

    a_ensure_press: assert property (@(posedge clk) disable iff (!rst_n)
        !(flags_reg[FLAG_ENSURE] && flags_reg[FLAG_PRESS]))
        else $error("ensure and press flags both set");

    a_hold_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        flags_reg[FLAG_HOLD] |-> flags_reg[FLAG_PRESS])
        else $error("hold flag without press");

    a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        !tick |=> $stable(flags_reg) && $stable(count_reg))
        else $error("state moved without a tick");
`endif

endmodule
